// ===== rtl/core/ssp_pkg.sv =====
// Shared constants for the stepper step pulse generator.
package ssp_pkg;

	localparam int CMD_W      = 11;
	localparam int MAG_W      = 10;
	localparam int DZ_W       = 10;
	localparam int MS_W       = 15;
	localparam int PW_W       = 10;
	localparam int SPD_W      = 16;
	localparam int CNT_W      = 20;
	localparam int PROD_W     = MAG_W + MS_W;
	localparam int FULL_SHIFT = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 15;

	localparam logic [CMD_W-1:0] FULL_CMD = CMD_W'(512);
	localparam logic [CNT_W-1:0] CNT_MAX  = '1;

	localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd2;

	localparam logic [DZ_W-1:0] DEADZONE_RST    = DZ_W'(25);
	localparam logic [MS_W-1:0] MAX_SPEED_RST   = MS_W'(100);
	localparam logic [PW_W-1:0] PULSE_WIDTH_RST = PW_W'(20);

endpackage

// ===== rtl/core/ssp_mul.sv =====
// Bit-serial shift-add multiplier: command magnitude times max speed.
module ssp_mul import ssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  mag,
	input  logic [MS_W-1:0]   max_speed,
	output logic              done,
	output logic [PROD_W-1:0] product
);

	localparam int CW = $clog2(MAG_W + 1);

	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [PROD_W-1:0] p_q;
	logic [MS_W:0]     sum;

	assign sum = {1'b0, p_q[PROD_W-1:MAG_W]} + (p_q[0] ? {1'b0, max_speed} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{MS_W{1'b0}}, mag};
		end else if (cnt_q != '0) begin
			p_q <= {sum, p_q[MAG_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = p_q;

endmodule

// ===== rtl/core/ssp_div.sv =====
// Restoring divider, one quotient bit per cycle: ticks per second over speed.
module ssp_div import ssp_pkg::*; #(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
	localparam int QW = $clog2(TICKS_PER_SECOND + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MS_W-1:0] divisor,
	output logic            done,
	output logic [QW-1:0]   quotient
);

	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0]   cnt_q;
	logic            done_q;
	logic [MS_W-1:0] rem_q;
	logic [QW-1:0]   q_q;
	logic [MS_W:0]   shifted;
	logic [MS_W+1:0] diff;
	logic            ge;

	assign shifted = {rem_q, q_q[QW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign ge      = !diff[MS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= QW'(TICKS_PER_SECOND);
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[MS_W-1:0] : shifted[MS_W-1:0];
			q_q   <= {q_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

// ===== rtl/core/stepper_step_pulse_generator_top.sv =====
// Stepper step/direction pulse generator: control, tick timing and output register.
// Tick item: result registered at transfer, visible next cycle; one tick per cycle unless held.
// Command item: multiply, then a QW-bit restoring divide, QW = clog2(TICKS_PER_SECOND+1);
// result registered when the divide is done; zero speed skips the divide, deadzone skips both.
// A new item is taken once the previous command is finished and the output register is free.
// Reset: speed, interval, elapsed and pulse count cleared, driver disabled, direction forward.
module stepper_step_pulse_generator_top import ssp_pkg::*; #(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic signed [CMD_W-1:0] command,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 driver_enabled,
	output logic                 forward,
	output logic                 pulse_active,
	output logic                 step_started,
	output logic signed [SPD_W-1:0] current_speed,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
	localparam int QX_W  = (TPS_W > CNT_W) ? TPS_W : CNT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

	state_t st_q;

	logic [DZ_W-1:0] dz_q;
	logic [MS_W-1:0] ms_q;
	logic [PW_W-1:0] pw_q;

	logic signed [SPD_W-1:0] speed_q;
	logic [CNT_W-1:0] interval_q;
	logic [CNT_W-1:0] elapsed_q;
	logic [PW_W-1:0]  pl_q;
	logic             en_q;
	logic             dir_q;
	logic             neg_q;

	logic             out_valid_q;
	logic             out_en_q;
	logic             out_fwd_q;
	logic             out_act_q;
	logic             out_start_q;
	logic signed [SPD_W-1:0] out_speed_q;

	logic             accept;
	logic             out_load;
	logic             cmd_neg;
	logic [CMD_W-1:0] cmd_abs;
	logic [MAG_W-1:0] mag;
	logic             dead;
	logic             mul_start;
	logic             mul_done;
	logic [PROD_W-1:0] product;
	logic [MS_W-1:0]  spd;
	logic signed [SPD_W-1:0] spd_signed;
	logic             div_start;
	logic             div_done;
	logic [TPS_W-1:0] quotient;
	logic [QX_W-1:0]  q_ext;
	logic [CNT_W-1:0] iv_sat;
	logic [CNT_W-1:0] eff_ext;
	logic [CNT_W-1:0] iv_final;
	logic [PW_W-1:0]  eff_w;

	logic             t_fwd;
	logic [CNT_W-1:0] t_e0;
	logic [CNT_W-1:0] t_e1;
	logic [CNT_W-1:0] t_elapsed;
	logic [PW_W-1:0]  t_pl;
	logic             t_en;
	logic             t_dir;
	logic             t_act;
	logic             t_start;

	assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign cmd_neg = command[CMD_W-1];
	assign cmd_abs = cmd_neg ? CMD_W'(-command) : CMD_W'(command);
	assign mag     = (cmd_abs > FULL_CMD) ? MAG_W'(FULL_CMD) : cmd_abs[MAG_W-1:0];
	assign dead    = mag < dz_q;

	assign mul_start = accept && op && !dead;

	ssp_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mul_start),
		.mag       (mag),
		.max_speed (ms_q),
		.done      (mul_done),
		.product   (product)
	);

	assign spd        = product[FULL_SHIFT+MS_W-1:FULL_SHIFT];
	assign spd_signed = neg_q ? -$signed({1'b0, spd}) : $signed({1'b0, spd});
	assign div_start  = (st_q == ST_MUL) && mul_done && (spd != '0);

	ssp_div #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (spd),
		.done     (div_done),
		.quotient (quotient)
	);

	assign out_load = (accept && (!op || dead)) ||
		((st_q == ST_MUL) && mul_done && (spd == '0)) ||
		((st_q == ST_DIV) && div_done);

	assign eff_w    = (pw_q == '0) ? PW_W'(1) : pw_q;
	assign eff_ext  = CNT_W'(eff_w);
	assign q_ext    = QX_W'(quotient);
	assign iv_sat   = (q_ext > QX_W'(CNT_MAX)) ? CNT_MAX : q_ext[CNT_W-1:0];
	assign iv_final = (iv_sat <= eff_ext) ? eff_ext + CNT_W'(1) : iv_sat;

	always_comb begin
		t_fwd     = !speed_q[SPD_W-1];
		t_e0      = elapsed_q;
		t_e1      = elapsed_q;
		t_elapsed = elapsed_q;
		t_pl      = pl_q;
		t_en      = en_q;
		t_dir     = dir_q;
		t_act     = 1'b0;
		t_start   = 1'b0;
		if (pl_q != '0) begin
			t_act = 1'b1;
			t_pl  = pl_q - PW_W'(1);
			if (pl_q == PW_W'(1)) begin
				t_elapsed = '0;
			end
		end else if (speed_q == '0) begin
			t_en = 1'b0;
			if (elapsed_q != CNT_MAX) begin
				t_elapsed = elapsed_q + CNT_W'(1);
			end
		end else begin
			t_en  = 1'b1;
			t_dir = t_fwd;
			if (dir_q != t_fwd) begin
				t_e0 = '0;
			end
			t_e1      = (t_e0 != CNT_MAX) ? t_e0 + CNT_W'(1) : t_e0;
			t_elapsed = t_e1;
			if (t_e1 >= interval_q) begin
				t_act     = 1'b1;
				t_start   = 1'b1;
				t_pl      = eff_w - PW_W'(1);
				t_elapsed = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DEADZONE_RST;
			ms_q <= MAX_SPEED_RST;
			pw_q <= PULSE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEADZONE:    dz_q <= cfg_data[DZ_W-1:0];
				REG_MAX_SPEED:   ms_q <= cfg_data[MS_W-1:0];
				REG_PULSE_WIDTH: pw_q <= cfg_data[PW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			speed_q     <= '0;
			interval_q  <= '0;
			elapsed_q   <= '0;
			pl_q        <= '0;
			en_q        <= 1'b0;
			dir_q       <= 1'b1;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_en_q    <= 1'b0;
			out_fwd_q   <= 1'b1;
			out_act_q   <= 1'b0;
			out_start_q <= 1'b0;
			out_speed_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept && !op) begin
						elapsed_q   <= t_elapsed;
						pl_q        <= t_pl;
						en_q        <= t_en;
						dir_q       <= t_dir;
						out_en_q    <= t_en;
						out_fwd_q   <= t_dir;
						out_act_q   <= t_act;
						out_start_q <= t_start;
						out_speed_q <= speed_q;
					end else if (accept) begin
						neg_q <= cmd_neg;
						if (dead) begin
							speed_q     <= '0;
							out_en_q    <= en_q;
							out_fwd_q   <= dir_q;
							out_act_q   <= (pl_q != '0);
							out_start_q <= 1'b0;
							out_speed_q <= '0;
						end else begin
							st_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						speed_q <= spd_signed;
						if (spd == '0) begin
							st_q        <= ST_IDLE;
							out_en_q    <= en_q;
							out_fwd_q   <= dir_q;
							out_act_q   <= (pl_q != '0);
							out_start_q <= 1'b0;
							out_speed_q <= spd_signed;
						end else begin
							st_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q        <= ST_IDLE;
						interval_q  <= iv_final;
						out_en_q    <= en_q;
						out_fwd_q   <= dir_q;
						out_act_q   <= (pl_q != '0);
						out_start_q <= 1'b0;
						out_speed_q <= speed_q;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign driver_enabled = out_en_q;
	assign forward        = out_fwd_q;
	assign pulse_active   = out_act_q;
	assign step_started   = out_start_q;
	assign current_speed  = out_speed_q;

endmodule

// ===== test/ssp_result_checker.sv =====
// Result checker for the stepper step pulse generator: predicts every result and compares it.
`timescale 1ns / 1ps
module ssp_result_checker import ssp_pkg::*; #(
	parameter int unsigned TICKS = TICKS_PER_SECOND_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic                    op,
	input  logic signed [CMD_W-1:0] command,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    driver_enabled,
	input  logic                    forward,
	input  logic                    pulse_active,
	input  logic                    step_started,
	input  logic signed [SPD_W-1:0] current_speed,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic                    en;
		logic                    fwd;
		logic                    act;
		logic                    stp;
		logic signed [SPD_W-1:0] spd;
	} motor_out_t;

	localparam int FULL_MAG = int'(FULL_CMD);

	motor_out_t expected_q[$];

	logic [DZ_W-1:0]         dz;
	logic [MS_W-1:0]         mspd;
	logic [PW_W-1:0]         pw;
	logic signed [SPD_W-1:0] tgt_speed;
	logic [CNT_W-1:0]        interval;
	logic [CNT_W-1:0]        elapsed;
	logic [PW_W-1:0]         pulse_cnt;
	logic                    drv_en;
	logic                    dir_fwd;

	function automatic logic [PW_W-1:0] width_eff();
		return (pw == '0) ? PW_W'(1) : pw;
	endfunction

	function automatic void take_command(input logic signed [CMD_W-1:0] raw);
		int          cmd;
		int unsigned mag;
		int unsigned spd;
		int unsigned iv;
		int unsigned wd;
		cmd = raw;
		if (cmd > FULL_MAG)
			cmd = FULL_MAG;
		if (cmd < -FULL_MAG)
			cmd = -FULL_MAG;
		mag = (cmd < 0) ? -cmd : cmd;
		if (mag < dz) begin
			tgt_speed = '0;
			return;
		end
		spd = (mag * mspd) >> FULL_SHIFT;
		tgt_speed = SPD_W'((cmd < 0) ? -int'(spd) : int'(spd));
		if (spd == 0)
			return;
		iv = TICKS / spd;
		if (iv > CNT_MAX)
			iv = CNT_MAX;
		wd = width_eff();
		if (iv <= wd)
			iv = wd + 1;
		interval = CNT_W'(iv);
	endfunction

	function automatic motor_out_t advance_motor(input logic is_cmd,
			input logic signed [CMD_W-1:0] raw);
		motor_out_t r;
		logic       act;
		logic       stp;
		act = 1'b0;
		stp = 1'b0;
		if (is_cmd) begin
			take_command(raw);
			act = (pulse_cnt != '0);
		end else if (pulse_cnt != '0) begin
			act = 1'b1;
			pulse_cnt--;
			if (pulse_cnt == '0)
				elapsed = '0;
		end else if (tgt_speed == 0) begin
			drv_en = 1'b0;
			if (elapsed != CNT_MAX)
				elapsed++;
		end else begin
			drv_en = 1'b1;
			if (dir_fwd != (tgt_speed > 0)) begin
				dir_fwd = (tgt_speed > 0);
				elapsed = '0;
			end
			if (elapsed != CNT_MAX)
				elapsed++;
			if (elapsed >= interval) begin
				act = 1'b1;
				stp = 1'b1;
				pulse_cnt = width_eff() - 1'b1;
				elapsed = '0;
			end
		end
		r.en  = drv_en;
		r.fwd = dir_fwd;
		r.act = act;
		r.stp = stp;
		r.spd = tgt_speed;
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [SPD_W-1:0] want,
			input logic signed [SPD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_result();
		motor_out_t want;
		if (expected_q.size() == 0) begin
			$error("result transfer with no item waiting");
			fail_count++;
		end else begin
			want = expected_q.pop_front();
			check_field("driver_enabled", want.en, driver_enabled);
			check_field("forward", want.fwd, forward);
			check_field("pulse_active", want.act, pulse_active);
			check_field("step_started", want.stp, step_started);
			check_field("current_speed", want.spd, current_speed);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz = DEADZONE_RST;
			mspd = MAX_SPEED_RST;
			pw = PULSE_WIDTH_RST;
			tgt_speed = '0;
			interval = '0;
			elapsed = '0;
			pulse_cnt = '0;
			drv_en = 1'b0;
			dir_fwd = 1'b1;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEADZONE:    dz = cfg_data[DZ_W-1:0];
					REG_MAX_SPEED:   mspd = cfg_data[MS_W-1:0];
					REG_PULSE_WIDTH: pw = cfg_data[PW_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready)
				compare_result();
			if (in_valid && in_ready)
				expected_q.push_back(advance_motor(op, command));
			pending = expected_q.size();
		end
	end

endmodule

// ===== test/tb_stepper_step_pulse_generator_top.sv =====
// Testbench top for the stepper step pulse generator: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_stepper_step_pulse_generator_top;
	import ssp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;
	localparam int   HOLD_CYCLES = 300;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    op;
	logic signed [CMD_W-1:0] command;
	logic                    out_valid;
	logic                    out_ready;
	logic                    driver_enabled;
	logic                    forward;
	logic                    pulse_active;
	logic                    step_started;
	logic signed [SPD_W-1:0] current_speed;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	int   fails;
	int   pending;
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	always #1 clk = ~clk;

	stepper_step_pulse_generator_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.command        (command),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.driver_enabled (driver_enabled),
		.forward        (forward),
		.pulse_active   (pulse_active),
		.step_started   (step_started),
		.current_speed  (current_speed),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	ssp_result_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.command        (command),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.driver_enabled (driver_enabled),
		.forward        (forward),
		.pulse_active   (pulse_active),
		.step_started   (step_started),
		.current_speed  (current_speed),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fails),
		.pending        (pending)
	);

	task automatic send_item(input logic o, input logic [CMD_W-1:0] c);
		while (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		command <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [DZ_W-1:0] dz, input logic [MS_W-1:0] ms,
			input logic [PW_W-1:0] pw);
		logic [CFG_W-1:0] w;
		cfg_we <= 1'b1;
		w = CFG_W'($urandom);
		w[DZ_W-1:0] = dz;
		cfg_index <= REG_DEADZONE;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_MAX_SPEED;
		cfg_data <= ms;
		@(posedge clk);
		w = CFG_W'($urandom);
		w[PW_W-1:0] = pw;
		cfg_index <= REG_PULSE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: random back-pressure plus one long hold-off
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			out_ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int               ph;
		int               k;
		logic [CMD_W-1:0] c;
		logic             neg;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_TICK;
		command <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DEADZONE;
		cfg_data <= '0;
		neg = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: saturation, deadzone edges, zero command
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, CMD_W'(1023));
		send_item(OP_TICK, '1);
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, CMD_W'(-1024));
		send_item(OP_TICK, '0);
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, CMD_W'(24));
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, CMD_W'(-25));
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, '0);
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, CMD_W'(512));
		drain();
		// zero pulse width, full max speed, no deadzone
		set_regs('0, '1, '0);
		send_item(OP_COMMAND, CMD_W'(-1));
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, CMD_W'(1));
		send_item(OP_TICK, '0);
		drain();
		// zero max speed, wide pulse
		set_regs(DZ_W'(512), '0, PW_W'(1000));
		send_item(OP_COMMAND, CMD_W'(512));
		send_item(OP_TICK, '0);
		send_item(OP_COMMAND, CMD_W'(-511));
		send_item(OP_TICK, '0);

		for (ph = 0; ph < 10; ph++) begin
			drain();
			case (ph)
				0: set_regs('0, '1, '0);
				1: set_regs(DZ_W'(512), '1, PW_W'(1000));
				2: set_regs('1, MS_W'(1), PW_W'(5));
				3: set_regs(DZ_W'($urandom_range(100)), '0, PW_W'($urandom_range(1, 50)));
				default: set_regs(DZ_W'($urandom_range(200)), MS_W'($urandom_range(12000, 32767)),
					PW_W'($urandom_range(1, 40)));
			endcase
			calm = (ph == 4);
			if (ph == 6)
				hold_req = 1'b1;
			for (k = 0; k < 200; k++) begin
				if (ph == 7 && k == 100)
					drain();
				if ($urandom_range(99) < 6) begin
					if ($urandom_range(99) < 20)
						neg = ~neg;
					case ($urandom_range(3))
						0, 1: c = CMD_W'($urandom_range(400, 512));
						2: c = CMD_W'($urandom_range(513, 1023));
						default: c = CMD_W'($urandom);
					endcase
					if (neg && !c[CMD_W-1])
						c = -c;
					send_item(OP_COMMAND, c);
				end else begin
					send_item(OP_TICK, CMD_W'($urandom));
				end
			end
		end
		drain();
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ssp_pkg.sv
rtl/core/ssp_mul.sv
rtl/core/ssp_div.sv
rtl/core/stepper_step_pulse_generator_top.sv
test/ssp_result_checker.sv
test/tb_stepper_step_pulse_generator_top.sv
